/* rtl/pemb64_pkg.sv */
// Shared types, constants and the base64 alphabet lookup for the PEM body decoder.
`timescale 1ns / 1ps

package pemb64_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int DELAY_LEN   = 5;
    localparam int CAP_W       = 16;

    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_UC_A  = 8'h41;
    localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LC_A  = 8'h61;
    localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_HEADER = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One queue entry: up to one data result then up to one status result.
    typedef struct packed {
        logic             has_data;
        logic [7:0]       data;
        logic             has_status;
        logic [1:0]       status;
        logic [CAP_W-1:0] count;
    } t_entry;

    // Returns {valid, sextet}.
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'd0;
        if (c >= ASCII_UC_A && c <= ASCII_UC_Z) begin
            d = c - ASCII_UC_A;
            r = {1'b1, d[5:0]};
        end else if (c >= ASCII_LC_A && c <= ASCII_LC_Z) begin
            d = c - ASCII_LC_A + 8'd26;
            r = {1'b1, d[5:0]};
        end else if (c >= ASCII_0 && c <= ASCII_9) begin
            d = c - ASCII_0 + 8'd52;
            r = {1'b1, d[5:0]};
        end else if (c == ASCII_PLUS) begin
            r = {1'b1, SEXTET_PLUS};
        end else if (c == ASCII_SLASH) begin
            r = {1'b1, SEXTET_SLASH};
        end
        return r;
    endfunction

endpackage

/* rtl/pemb64_front.sv */
// Front end: header skip, five-byte delay line, sextet accumulator, byte count.
`timescale 1ns / 1ps

module pemb64_front
    import pemb64_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [2:0] FILL_FULL = 3'(DELAY_LEN);

    logic [CAP_W-1:0] r_cap;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_dly [DELAY_LEN];
    logic [7:0]       n_dly [DELAY_LEN];
    logic [2:0]       r_fill, n_fill;
    logic [5:0]       r_acc, n_acc;
    logic [2:0]       r_acc_bits, n_acc_bits;
    logic [CAP_W-1:0] r_count, n_count;

    logic [6:0]  lookup;
    logic [11:0] total;
    logic [2:0]  shift;
    logic        emit;
    logic [7:0]  dec_byte;
    t_entry      ent;

    always_comb begin
        n_phase    = r_phase;
        n_dly      = r_dly;
        n_fill     = r_fill;
        n_acc      = r_acc;
        n_acc_bits = r_acc_bits;
        n_count    = r_count;
        emit       = 1'b0;
        dec_byte   = 8'd0;
        lookup     = f_sextet(r_dly[0]);
        total      = {r_acc, lookup[5:0]};
        shift      = r_acc_bits - 3'd2;
        ent        = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (i_text_byte == ASCII_LF) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_fill < FILL_FULL) begin
                    n_dly[r_fill[2:0]] = i_text_byte;
                    n_fill = r_fill + 3'd1;
                end else if (r_dly[0] == ASCII_DASH && r_dly[1] == ASCII_DASH) begin
                    n_phase = PH_STOP;
                end else begin
                    if (r_count < r_cap && lookup[6]) begin
                        if (r_acc_bits != 3'd0) begin
                            // Completes a byte, leftover bits stay in the accumulator.
                            dec_byte   = 8'(total >> shift);
                            n_acc      = 6'(total & ((12'd1 << shift) - 12'd1));
                            n_acc_bits = shift;
                            n_count    = r_count + 1'b1;
                            emit       = 1'b1;
                        end else begin
                            n_acc      = lookup[5:0];
                            n_acc_bits = 3'd6;
                        end
                    end
                    for (int k = 0; k < DELAY_LEN - 1; k++) begin
                        n_dly[k] = r_dly[k+1];
                    end
                    n_dly[DELAY_LEN-1] = i_text_byte;
                end
            end
            default: ; // stopped, and the unused code
        endcase

        ent.has_data = emit;
        ent.data     = dec_byte;

        if (i_end_of_text) begin
            ent.has_status = 1'b1;
            if (n_phase == PH_HEADER) begin
                ent.status = STATUS_NO_HEADER;
                ent.count  = '0;
            end else begin
                ent.status = (n_count != '0) ? STATUS_OK : STATUS_EMPTY;
                ent.count  = n_count;
            end
            n_phase    = PH_HEADER;
            n_fill     = 3'd0;
            n_acc      = 6'd0;
            n_acc_bits = 3'd0;
            n_count    = '0;
        end
    end

    assign o_push  = i_accept && (ent.has_data || ent.has_status);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= '1;
            r_phase    <= PH_HEADER;
            r_fill     <= 3'd0;
            r_acc      <= 6'd0;
            r_acc_bits <= 3'd0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_fill     <= n_fill;
                r_acc      <= n_acc;
                r_acc_bits <= n_acc_bits;
                r_count    <= n_count;
            end
        end
    end

    // Delay line payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_dly <= n_dly;
        end
    end

    a_acc_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc_bits[0] && r_acc_bits <= 3'd6)
        else $error("accumulator bit count out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("delay fill past its length");

endmodule

/* rtl/pemb64_queue.sv */
// Small FIFO of result entries between the front and back ends.
`timescale 1ns / 1ps

module pemb64_queue
    import pemb64_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_entry            r_mem [Depth];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_cnt;

    function automatic logic [PtrW-1:0] f_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* rtl/pemb64_back.sv */
// Back end: expands queue entries into result beats through an output register.
`timescale 1ns / 1ps

module pemb64_back
    import pemb64_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_entry           i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_kind,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic [CAP_W-1:0] o_byte_count,
    output logic             o_run_last
);

    logic             r_valid, n_valid;
    logic             r_data_done, n_data_done;
    logic             r_kind, n_kind;
    logic [7:0]       r_byte, n_byte;
    logic [1:0]       r_status, n_status;
    logic [CAP_W-1:0] r_count, n_count;
    logic             r_last, n_last;
    logic             out_free, load;

    always_comb begin
        out_free    = !r_valid || i_out_ready;
        load        = 1'b0;
        o_pop       = 1'b0;
        n_data_done = r_data_done;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_status    = r_status;
        n_count     = r_count;
        n_last      = r_last;
        if (out_free && i_q_valid) begin
            load = 1'b1;
            if (i_head.has_data && !r_data_done) begin
                n_kind   = KIND_DATA;
                n_byte   = i_head.data;
                n_status = STATUS_OK;
                n_count  = '0;
                n_last   = !i_head.has_status;
                if (i_head.has_status) begin
                    n_data_done = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_kind      = KIND_STATUS;
                n_byte      = 8'd0;
                n_status    = i_head.status;
                n_count     = i_head.count;
                n_last      = 1'b1;
                n_data_done = 1'b0;
                o_pop       = 1'b1;
            end
        end
        n_valid = load || (r_valid && !out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_data_done <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_data_done <= n_data_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_status <= n_status;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_status     = r_status;
    assign o_byte_count = r_count;
    assign o_run_last   = r_last;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_STATUS) |-> r_last)
        else $error("status beat without run_last");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_DATA) |-> (r_status == STATUS_OK && r_count == '0))
        else $error("data beat carries status fields");

endmodule

/* rtl/pem_base64_body_decoder.sv */
// Top level of the PEM base64 body decoder.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready): one PEM text byte per beat, with
//   i_end_of_text set on the final byte. Header bytes up to the first newline
//   are dropped; the body passes a five-byte delay line, so the last five
//   bytes of a text are never decoded, and decoding ends at a "--" pair.
//   Output channel (o_out_valid / i_out_ready): decoded bytes (o_kind = 0),
//   then one status beat (o_kind = 1) with the byte count after the last item.
//   o_run_last marks the final beat caused by one input item.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): output capacity.
// Timing:
//   An input beat is taken every cycle while the result queue has room. The
//   front end finishes each byte in the accepting cycle; the entry then passes
//   the result queue and the output register before o_out_valid rises.
//   An item that yields a data byte and a status gives two output beats, sent
//   by the single output register draining the queue one beat per cycle while i_out_ready is high.
// Reset: synchronous active-low; clears parse state, queue and output valid,
//   capacity returns to 65535. After each end-of-text item the parse state
//   clears so the next byte starts a new text.
// Stall: when i_out_ready is low the output holds, the queue fills
//   (QueueDepth entries), then o_in_ready drops until space frees up.

module pem_base64_body_decoder
    import pemb64_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_kind,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic [CAP_W-1:0] o_byte_count,
    output logic             o_run_last
);

    logic   q_full, q_valid, push, pop, accept;
    t_entry push_entry, head_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign accept      = i_in_valid && !q_full;

    pemb64_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    pemb64_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_entry)
    );

    pemb64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_head       (head_entry),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last)
    );

endmodule

/* verif/tb_pem_base64_body_decoder.sv */
// Self-checking testbench for the PEM base64 body decoder.
`timescale 1ns / 1ps

// Drives PEM texts one byte per beat and predicts every decoded byte and
// end-status beat in a scoreboard of its own. The predictor mirrors the block:
// it skips the header up to the first newline, runs body bytes through a
// five-byte lookahead, stops at a "--" pair, drops bytes outside the base64
// alphabet, and packs sextets MSB first until the capacity is reached.
// The run covers directed corner texts, random traffic under four idle and
// stall mixes, and one long output hold that fills the block and stalls input.
module tb_pem_base64_body_decoder;
    import pemb64_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 4;
    // Accept to o_out_valid passes the result queue and the output register, behind up to QUEUE_DEPTH queued beats.
    localparam int DRAIN_CYCLES = 8;
    // Longest hold is HOLD_CYCLES; random stalls are short geometric runs.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_GAP      = 32;
    localparam logic [CAP_W-1:0] CAP_MAX = '1;

    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_BODY,
        SCAN_STOPPED
    } t_scan_phase;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [1:0]       status;
        logic [CAP_W-1:0] count;
        logic             run_last;
    } t_decoded_beat;

    // DUT ports; every input known from time zero.
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_valid   = 1'b0;
    logic [CAP_W-1:0] i_cfg_data    = '0;
    logic             i_in_valid    = 1'b0;
    logic [7:0]       i_text_byte   = 8'd0;
    logic             i_end_of_text = 1'b0;
    logic             i_out_ready   = 1'b0;
    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_kind;
    logic [7:0]       o_out_byte;
    logic [1:0]       o_status;
    logic [CAP_W-1:0] o_byte_count;
    logic             o_run_last;

    // Predictor state: one text in flight plus the capacity register.
    t_scan_phase      scan_phase;
    logic [7:0]       lookahead [DELAY_LEN];
    int               lookahead_fill;
    logic [5:0]       bit_acc;
    int               bit_acc_len;
    logic [CAP_W-1:0] bytes_decoded;
    logic [CAP_W-1:0] out_capacity;
    int               sextet_lut [256];
    string            b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    t_decoded_beat    beats_due [$];
    logic [7:0]       text_buf [$];

    // Traffic knobs, percent per cycle.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    // Bookkeeping.
    int errors       = 0;
    int in_beats     = 0;
    int texts_sent   = 0;
    int cap_writes   = 0;
    int data_beats   = 0;
    int status_beats = 0;
    int stuck_cycles = 0;

    pem_base64_body_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count),
        .o_run_last    (o_run_last)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_text_state();
        scan_phase     = SCAN_HEADER;
        lookahead_fill = 0;
        bit_acc        = 6'd0;
        bit_acc_len    = 0;
        bytes_decoded  = '0;
        foreach (lookahead[i]) lookahead[i] = 8'd0;
    endtask

    // Sextet value per byte, -1 outside the alphabet.
    task automatic build_sextet_lut();
        foreach (sextet_lut[i]) sextet_lut[i] = -1;
        for (int i = 0; i < b64_alphabet.len(); i++) sextet_lut[b64_alphabet[i]] = i;
    endtask

    // Works out the beats caused by one accepted text byte, queues them.
    task automatic predict_decoded_beats(input logic [7:0] c, input logic eot);
        logic [11:0]   merged;
        logic [7:0]    oldest;
        int            nbits;
        int            sextet;
        t_decoded_beat beat;
        t_decoded_beat batch [$];

        case (scan_phase)
            SCAN_HEADER: begin
                if (c == ASCII_LF) scan_phase = SCAN_BODY;
            end
            SCAN_BODY: begin
                if (lookahead_fill < DELAY_LEN) begin
                    lookahead[lookahead_fill] = c;
                    lookahead_fill++;
                end else if (lookahead[0] == ASCII_DASH && lookahead[1] == ASCII_DASH) begin
                    scan_phase = SCAN_STOPPED;
                end else begin
                    oldest = lookahead[0];
                    sextet = sextet_lut[oldest];
                    // Capacity is checked against the live register value.
                    if (bytes_decoded < out_capacity && sextet >= 0) begin
                        merged = {bit_acc, sextet[5:0]};
                        nbits  = bit_acc_len + 6;
                        if (nbits >= 8) begin
                            nbits -= 8;
                            beat = '{KIND_DATA, 8'(merged >> nbits), STATUS_OK, 16'd0, 1'b0};
                            batch.push_back(beat);
                            bit_acc = 6'(merged & ((12'd1 << nbits) - 12'd1));
                            bytes_decoded++;
                        end else begin
                            bit_acc = merged[5:0];
                        end
                        bit_acc_len = nbits;
                    end
                    for (int i = 0; i < DELAY_LEN - 1; i++) lookahead[i] = lookahead[i + 1];
                    lookahead[DELAY_LEN - 1] = c;
                end
            end
            default: begin
            end
        endcase

        // Status goes after any data byte from the same item.
        if (eot) begin
            if (scan_phase == SCAN_HEADER) begin
                beat = '{KIND_STATUS, 8'd0, STATUS_NO_HEADER, 16'd0, 1'b0};
            end else begin
                beat = '{KIND_STATUS, 8'd0,
                         (bytes_decoded != 0) ? STATUS_OK : STATUS_EMPTY,
                         bytes_decoded, 1'b0};
            end
            batch.push_back(beat);
            clear_text_state();
        end

        if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[i]) beats_due.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------------
    // Drivers: inputs move at the falling edge, handshakes seen at rising
    // ------------------------------------------------------------------

    // Valid stays high after a beat; whoever stops sending must drop it.
    task automatic send_beat(input logic [7:0] b, input logic eot);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        in_beats++;
        predict_decoded_beats(b, eot);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_beat(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    task automatic send_str(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // Drop valid, let every expected beat drain, then allow for items
    // still in the pipe that produce nothing.
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        out_capacity = value;
        cap_writes++;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 30) return CAP_W'($urandom_range(1, 6));
        if (r < 60) return CAP_MAX;
        return CAP_W'($urandom_range(0, 65535));
    endfunction

    // Mostly well-formed texts with random content; some with the header
    // newline missing, some plain noise.
    task automatic build_random_text();
        int         kind_sel;
        int         n;
        logic [7:0] b;
        text_buf.delete();
        kind_sel = $urandom_range(0, 99);
        if (kind_sel < 12) begin
            n = $urandom_range(1, 12);
            repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 254));
            if (b >= ASCII_LF) b++;
            text_buf.push_back(b);
        end
        if (kind_sel >= 20) text_buf.push_back(ASCII_LF);
        // Occasional long body so capacity and byte counts go beyond a few.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 40);
        repeat (n) begin
            if ($urandom_range(0, 99) < 8) text_buf.push_back(8'($urandom_range(0, 255)));
            else text_buf.push_back(b64_alphabet[$urandom_range(0, 63)]);
        end
        if ($urandom_range(0, 3) != 0) begin
            text_buf.push_back(ASCII_DASH);
            text_buf.push_back(ASCII_DASH);
            repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Receiver, scoreboard, watchdog
    // ------------------------------------------------------------------

    // Output ready: a counted hold when asked, else random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_decoded_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beats_due.size() == 0) begin
                $error("unexpected beat: kind %0d byte %02h status %0d count %0d",
                       o_kind, o_out_byte, o_status, o_byte_count);
                errors++;
            end else begin
                want = beats_due.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errors++;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_byte_count !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, o_byte_count);
                    errors++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0d, got %0d", want.run_last, o_run_last);
                    errors++;
                end
                if (want.kind == KIND_DATA) data_beats++;
                else status_beats++;
            end
        end
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d beats outstanding",
                         IDLE_LIMIT, beats_due.size());
                $display("pem_base64_body_decoder regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme byte values, header never closed: status says no newline.
    task automatic test_no_header_newline();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
    endtask

    // Newline as the only and final byte: header found, body empty.
    task automatic test_newline_final_byte();
        send_beat(ASCII_LF, 1'b1);
    endtask

    // Every alphabet range, then a "--" pair reaching the front of the
    // lookahead so decoding stops before the text ends.
    task automatic test_alphabet_and_dash_stop();
        send_str("\nAz9+/--abcd");
    endtask

    // Capacity of one: the second examined sextet completes the byte,
    // later valid bytes are neither decoded nor accumulated.
    task automatic test_capacity_limit();
        write_capacity(16'd1);
        send_str("\nQUJD++++");
    endtask

    // Capacity zero: valid body, nothing decoded, status empty.
    task automatic test_capacity_zero();
        write_capacity('0);
        send_str("\nQUJDRA");
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct_arg,
                                       input logic [CAP_W-1:0] first_cap);
        int start_items;
        int texts_here;
        write_capacity(first_cap);
        send_idle_pct = idle_pct;
        stall_pct     = stall_pct_arg;
        start_items   = in_beats;
        texts_here    = 0;
        while (in_beats - start_items < PHASE_ITEMS) begin
            if (texts_here != 0 && texts_here % 6 == 0) write_capacity(pick_capacity());
            build_random_text();
            send_text();
            texts_here++;
        end
    endtask

    // Output held for a long stretch while a long body streams in: the
    // result queue fills and input ready must drop until the hold ends.
    task automatic test_backpressure();
        write_capacity(CAP_MAX);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        text_buf.delete();
        text_buf.push_back(ASCII_LF);
        repeat (120) text_buf.push_back(b64_alphabet[$urandom_range(0, 63)]);
        repeat (2) text_buf.push_back(ASCII_DASH);
        repeat (5) text_buf.push_back(8'($urandom_range(0, 255)));
        send_text();
    endtask

    initial begin
        build_sextet_lut();
        clear_text_state();
        out_capacity = CAP_MAX;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_header_newline();
        test_newline_final_byte();
        test_alphabet_and_dash_stop();
        test_capacity_limit();
        test_capacity_zero();

        test_random_traffic(0, 0, CAP_MAX);
        test_random_traffic(56, 0, '0);
        test_random_traffic(0, 56, CAP_W'(3));
        test_random_traffic(37, 37, CAP_W'($urandom_range(7, 65534)));
        test_backpressure();

        wait_idle();
        $display("run covered %0d texts in %0d input beats with %0d capacity writes",
                 texts_sent, in_beats, cap_writes);
        $display("checked %0d decoded bytes and %0d end-status beats, %0d mismatches",
                 data_beats, status_beats, errors);
        if (errors == 0) begin
            $display("pem_base64_body_decoder regression: pass");
        end else begin
            $display("pem_base64_body_decoder regression: fail");
        end
        $finish;
    end

endmodule
